>>> hdl/dstwr_pkg.sv
package dstwr_pkg;

   // width of the timestamp fields on the ports
   localparam int STAMP_W = 40;

   localparam int TS_BITS_DEF = 40;
   localparam int TS_BITS_MAX = 48;

   // quotient bits kept; any larger time of flight saturates the distance
   localparam int QUO_W = 18;

   localparam int DIST_W = 16;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   // centimetre scaling: tof * 46903 / 100000, truncating
   localparam longint SCALE_NUM = 46903;
   localparam longint SCALE_DEN = 100000;
   localparam int SCALE_NUM_W = 16;
   localparam int SCALE_SHIFT = 20;
   localparam longint SCALE_RECIP = (SCALE_NUM << SCALE_SHIFT) / SCALE_DEN;
   localparam int RECIP_W = 19;

   typedef struct packed {
      logic neg;
      logic zero;
      logic ovf;
   } flags_type;

endpackage

>>> hdl/ds_twr_if.sv
interface ds_twr_req_if;
   logic valid;
   logic ready;
   logic [dstwr_pkg::STAMP_W-1:0] poll_tx_time;
   logic [dstwr_pkg::STAMP_W-1:0] poll_rx_time;
   logic [dstwr_pkg::STAMP_W-1:0] resp_tx_time;
   logic [dstwr_pkg::STAMP_W-1:0] resp_rx_time;
   logic [dstwr_pkg::STAMP_W-1:0] final_tx_time;
   logic [dstwr_pkg::STAMP_W-1:0] final_rx_time;

   modport source (
      output valid, poll_tx_time, poll_rx_time, resp_tx_time, resp_rx_time,
      output final_tx_time, final_rx_time,
      input ready
   );
   modport sink (
      input valid, poll_tx_time, poll_rx_time, resp_tx_time, resp_rx_time,
      input final_tx_time, final_rx_time,
      output ready
   );
endinterface

interface ds_twr_rsp_if;
   logic valid;
   logic ready;
   logic [dstwr_pkg::DIST_W-1:0] distance_cm;
   logic valid_res;
   logic saturated;

   modport source (
      output valid, distance_cm, valid_res, saturated,
      input ready
   );
   modport sink (
      input valid, distance_cm, valid_res, saturated,
      output ready
   );
endinterface

>>> hdl/ds_twr_distance_top.sv
// the pipeline has 8 + QUO_W register stages
// throughput: one word per cycle while the output is not stalled; the restoring
// divider resolves one quotient bit per stage
// a stalled output only holds the pipeline where every stage is full; bubbles collapse
// reset (synchronous, active high) clears the stage valid bits; data registers are not reset
module ds_twr_distance_top #(
   parameter int TIMESTAMP_BITS = dstwr_pkg::TS_BITS_DEF
) (
   input logic clock,
   input logic reset,
   ds_twr_req_if.sink req,
   ds_twr_rsp_if.source rsp
);

   localparam int TB  = TIMESTAMP_BITS;
   localparam int H   = (TB + 1) / 2;
   localparam int PPW = 2 * H;
   localparam int FW  = 4 * H;
   localparam int PW  = 2 * TB;
   localparam int SW  = TB + 2;
   localparam int QB  = dstwr_pkg::QUO_W;
   localparam int HW  = PW - QB;
   localparam int NST = QB + 8;
   localparam int MW  = QB + dstwr_pkg::RECIP_W;
   localparam int EW  = MW - dstwr_pkg::SCALE_SHIFT;
   localparam int XW  = QB + dstwr_pkg::SCALE_NUM_W;
   localparam int MX  = dstwr_pkg::TS_BITS_MAX;

   logic [NST-1:0] v_ff;
   logic [NST-1:0] en;

   // stall chain: a stage moves when empty or when the next one moves
   always_comb begin
      en[NST-1] = !v_ff[NST-1] || rsp.ready;
      for (int i = NST - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req.valid;
         end
         for (int i = 1; i < NST; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // stage 0: wrapped intervals are plain differences modulo the counter range
   logic [MX-1:0] t1_x, t2_x, t3_x, t4_x, t5_x, t6_x;
   logic [TB-1:0] ra_in, rb_in, da_in, db_in;
   logic [TB-1:0] ra_ff, rb_ff, da_ff, db_ff;

   assign t1_x = MX'(req.poll_tx_time);
   assign t2_x = MX'(req.poll_rx_time);
   assign t3_x = MX'(req.resp_tx_time);
   assign t4_x = MX'(req.resp_rx_time);
   assign t5_x = MX'(req.final_tx_time);
   assign t6_x = MX'(req.final_rx_time);

   assign ra_in = t4_x[TB-1:0] - t1_x[TB-1:0];
   assign rb_in = t6_x[TB-1:0] - t3_x[TB-1:0];
   assign da_in = t5_x[TB-1:0] - t4_x[TB-1:0];
   assign db_in = t3_x[TB-1:0] - t2_x[TB-1:0];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ra_ff <= ra_in;
         rb_ff <= rb_in;
         da_ff <= da_in;
         db_ff <= db_in;
      end
   end

   // stage 1: half-width partial products and the divisor
   logic [PPW-1:0] ra_p, rb_p, da_p, db_p;
   logic [PPW-1:0] r_ll_ff, r_lh_ff, r_hl_ff, r_hh_ff;
   logic [PPW-1:0] d_ll_ff, d_lh_ff, d_hl_ff, d_hh_ff;
   logic [SW-1:0]  sum_in;
   logic [SW-1:0]  sum1_ff, sum2_ff, sum3_ff;

   assign ra_p = PPW'(ra_ff);
   assign rb_p = PPW'(rb_ff);
   assign da_p = PPW'(da_ff);
   assign db_p = PPW'(db_ff);
   assign sum_in = SW'(ra_ff) + SW'(rb_ff) + SW'(da_ff) + SW'(db_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         r_ll_ff <= PPW'(ra_p[H-1:0]) * PPW'(rb_p[H-1:0]);
         r_lh_ff <= PPW'(ra_p[H-1:0]) * PPW'(rb_p[PPW-1:H]);
         r_hl_ff <= PPW'(ra_p[PPW-1:H]) * PPW'(rb_p[H-1:0]);
         r_hh_ff <= PPW'(ra_p[PPW-1:H]) * PPW'(rb_p[PPW-1:H]);
         d_ll_ff <= PPW'(da_p[H-1:0]) * PPW'(db_p[H-1:0]);
         d_lh_ff <= PPW'(da_p[H-1:0]) * PPW'(db_p[PPW-1:H]);
         d_hl_ff <= PPW'(da_p[PPW-1:H]) * PPW'(db_p[H-1:0]);
         d_hh_ff <= PPW'(da_p[PPW-1:H]) * PPW'(db_p[PPW-1:H]);
         sum1_ff <= sum_in;
      end
   end

   // stage 2: full products
   logic [FW-1:0] rp_full, dp_full;
   logic [PW-1:0] rp_ff, dp_ff;

   assign rp_full = (FW'(r_hh_ff) << PPW) + (FW'(r_lh_ff) << H)
                  + (FW'(r_hl_ff) << H) + FW'(r_ll_ff);
   assign dp_full = (FW'(d_hh_ff) << PPW) + (FW'(d_lh_ff) << H)
                  + (FW'(d_hl_ff) << H) + FW'(d_ll_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         rp_ff   <= rp_full[PW-1:0];
         dp_ff   <= dp_full[PW-1:0];
         sum2_ff <= sum1_ff;
      end
   end

   // stage 3: numerator, borrow marks a reply product above the round product
   logic [PW:0]   diff;
   logic [PW-1:0] num_ff;
   logic          neg_ff;

   assign diff = {1'b0, rp_ff} - {1'b0, dp_ff};

   always_ff @(posedge clock) begin
      if (en[3]) begin
         num_ff  <= diff[PW-1:0];
         neg_ff  <= diff[PW];
         sum3_ff <= sum2_ff;
      end
   end

   // stage 4: quotient range check, then one restoring step per stage
   logic [SW-1:0]             rem_ff [QB+1];
   logic [QB-1:0]             nb_ff  [QB+1];
   logic [QB-1:0]             quo_ff [QB+1];
   logic [SW-1:0]             dsum_ff[QB+1];
   dstwr_pkg::flags_type      dflg_ff[QB+1];

   logic [HW-1:0]         num_hi;
   dstwr_pkg::flags_type  flg_in;

   assign num_hi = num_ff[PW-1:QB];

   always_comb begin
      flg_in.neg  = neg_ff;
      flg_in.zero = (sum3_ff == '0);
      flg_in.ovf  = (num_hi >= HW'(sum3_ff)) && (sum3_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         rem_ff[0]  <= num_hi[SW-1:0];
         nb_ff[0]   <= num_ff[QB-1:0];
         quo_ff[0]  <= '0;
         dsum_ff[0] <= sum3_ff;
         dflg_ff[0] <= flg_in;
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_div
      logic [SW:0]   trial;
      logic          take;
      logic [SW:0]   trial_sub;

      assign trial     = {rem_ff[j-1], nb_ff[j-1][QB-1]};
      assign take      = trial >= {1'b0, dsum_ff[j-1]};
      assign trial_sub = trial - {1'b0, dsum_ff[j-1]};

      always_ff @(posedge clock) begin
         if (en[4+j]) begin
            rem_ff[j]  <= take ? trial_sub[SW-1:0] : trial[SW-1:0];
            nb_ff[j]   <= nb_ff[j-1] << 1;
            quo_ff[j]  <= {quo_ff[j-1][QB-2:0], take};
            dsum_ff[j] <= dsum_ff[j-1];
            dflg_ff[j] <= dflg_ff[j-1];
         end
      end
   end

   // scaling: estimate by reciprocal, exact product kept for the correction
   logic [MW-1:0]        mulr_ff;
   logic [XW-1:0]        prod_a_ff, prod_b_ff;
   logic [EW-1:0]        est_ff;
   logic [XW-1:0]        emul_ff;
   dstwr_pkg::flags_type fl_a_ff, fl_b_ff;

   always_ff @(posedge clock) begin
      if (en[5+QB]) begin
         mulr_ff   <= MW'(quo_ff[QB]) * MW'(dstwr_pkg::SCALE_RECIP);
         prod_a_ff <= XW'(quo_ff[QB]) * XW'(dstwr_pkg::SCALE_NUM);
         fl_a_ff   <= dflg_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en[6+QB]) begin
         est_ff    <= mulr_ff[MW-1:dstwr_pkg::SCALE_SHIFT];
         emul_ff   <= XW'(mulr_ff[MW-1:dstwr_pkg::SCALE_SHIFT]) * XW'(dstwr_pkg::SCALE_DEN);
         prod_b_ff <= prod_a_ff;
         fl_b_ff   <= fl_a_ff;
      end
   end

   // output stage
   logic [XW-1:0]               resid;
   logic                        bump;
   logic [EW:0]                 est_fix;
   logic                        big;
   logic                        sat_in;
   logic [dstwr_pkg::DIST_W-1:0] dist_in;
   logic [dstwr_pkg::DIST_W-1:0] dist_ff;
   logic                        vres_ff;
   logic                        sat_ff;

   assign resid   = prod_b_ff - emul_ff;
   assign bump    = resid >= XW'(dstwr_pkg::SCALE_DEN);
   assign est_fix = (EW+1)'(est_ff) + (EW+1)'(bump);
   assign big     = est_fix > (EW+1)'(dstwr_pkg::DIST_MAX);
   assign sat_in  = !fl_b_ff.neg && !fl_b_ff.zero && (fl_b_ff.ovf || big);

   always_comb begin
      priority if (fl_b_ff.neg || fl_b_ff.zero) begin
         dist_in = '0;
      end else if (sat_in) begin
         dist_in = dstwr_pkg::DIST_MAX;
      end else begin
         dist_in = est_fix[dstwr_pkg::DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[NST-1]) begin
         dist_ff <= dist_in;
         vres_ff <= !fl_b_ff.neg;
         sat_ff  <= sat_in;
      end
   end

   assign rsp.valid       = v_ff[NST-1];
   assign rsp.distance_cm = dist_ff;
   assign rsp.valid_res   = vres_ff;
   assign rsp.saturated   = sat_ff;

   // input only refused when every stage is holding a word
   a_full_when_refused: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (&v_ff))
      else $error("input refused with a bubble in the pipeline");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.valid_res |-> (rsp.distance_cm == '0) && !rsp.saturated)
      else $error("invalid word carries a distance");

   a_sat_is_max: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.saturated |-> rsp.valid_res && (rsp.distance_cm == dstwr_pkg::DIST_MAX))
      else $error("saturated word not clamped");

   a_last_stage_fills: assert property (@(posedge clock) disable iff (reset)
      en[NST-1] && v_ff[NST-2] |=> v_ff[NST-1])
      else $error("word lost entering output stage");

   a_est_low: assert property (@(posedge clock) disable iff (reset)
      v_ff[NST-1] == v_ff[NST-1] && v_ff[6+QB] |-> resid < XW'(2 * dstwr_pkg::SCALE_DEN))
      else $error("reciprocal estimate off by more than one");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int TS_BITS = dstwr_pkg::TS_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   typedef logic [dstwr_pkg::STAMP_W-1:0] stamp_type;

   typedef struct packed {
      stamp_type t1;
      stamp_type t2;
      stamp_type t3;
      stamp_type t4;
      stamp_type t5;
      stamp_type t6;
   } exchange_type;

   typedef struct packed {
      logic [dstwr_pkg::DIST_W-1:0] dist_cm;
      logic                         ok;
      logic                         sat;
   } range_type;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   error_count = 0;
   int   words_sent = 0;
   int   stall_left = 0;
   bit   stall_done = 0;
   bit   stim_done = 0;
   bit   req_wait = 0;

   exchange_type pending_words[$];
   range_type    expected_ranges[$];

   ds_twr_req_if req_bus ();
   ds_twr_rsp_if rsp_bus ();

   ds_twr_distance_top #(.TIMESTAMP_BITS(TS_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus)
   );

   function automatic range_type compute_range(exchange_type x);
      logic [63:0]  wrap, t1, t2, t3, t4, t5, t6, ra, rb, da, db, span, scaled;
      logic [127:0] round_prod, reply_prod, quo;
      range_type    r;
      wrap = 64'd1 << TS_BITS;
      t1 = x.t1 & (wrap - 1);
      t2 = x.t2 & (wrap - 1);
      t3 = x.t3 & (wrap - 1);
      t4 = x.t4 & (wrap - 1);
      t5 = x.t5 & (wrap - 1);
      t6 = x.t6 & (wrap - 1);
      if (t4 < t1) begin
         t4 += wrap;
         t5 += wrap;
      end
      if (t5 < t4) t5 += wrap;
      if (t3 < t2) begin
         t3 += wrap;
         t6 += wrap;
      end
      if (t6 < t3) t6 += wrap;
      ra = t4 - t1;
      rb = t6 - t3;
      da = t5 - t4;
      db = t3 - t2;
      round_prod = {64'd0, ra} * {64'd0, rb};
      reply_prod = {64'd0, da} * {64'd0, db};
      r = '0;
      if (round_prod < reply_prod) return r;
      r.ok = 1'b1;
      span = ra + rb + da + db;
      quo = (span == 0) ? 128'd0 : (round_prod - reply_prod) / {64'd0, span};
      if (quo > 128'hFFFF_FFFF) begin
         r.sat = 1'b1;
      end else begin
         scaled = quo[63:0] * 64'(dstwr_pkg::SCALE_NUM) / 64'(dstwr_pkg::SCALE_DEN);
         if (scaled > 64'hFFFF) r.sat = 1'b1;
         else r.dist_cm = scaled[dstwr_pkg::DIST_W-1:0];
      end
      if (r.sat) r.dist_cm = dstwr_pkg::DIST_MAX;
      return r;
   endfunction

   // a consistent exchange from the tag and anchor start stamps, a flight time and the reply delays da and db
   function automatic exchange_type make_exchange(stamp_type tag0, stamp_type anc0,
                                                  longint unsigned tof,
                                                  longint unsigned da,
                                                  longint unsigned db);
      exchange_type x;
      x.t1 = tag0;
      x.t2 = anc0;
      x.t3 = stamp_type'(anc0 + db);
      x.t4 = stamp_type'(tag0 + 2 * tof + db);
      x.t5 = stamp_type'(x.t4 + da);
      x.t6 = stamp_type'(x.t3 + da + 2 * tof);
      return x;
   endfunction

   function automatic stamp_type rand_stamp();
      return stamp_type'({$urandom(), $urandom()});
   endfunction

   task automatic report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got,
               want);
      error_count++;
   endtask

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // request side: predict on acceptance
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         expected_ranges.push_back(compute_range(pending_words[0]));
         pending_words.pop_front();
         words_sent <= words_sent + 1;
      end
      req_wait <= !reset && req_bus.valid && !req_bus.ready;
   end

   // driver: hold a word until taken, otherwise idle at random
   always @(negedge clock) begin
      exchange_type x;
      bit           drive;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         drive = pending_words.size() != 0 &&
                 (req_wait ||
                  (words_sent >= 300 && words_sent < 500) || $urandom_range(99) >= 23);
         if (drive) begin
            x = pending_words[0];
            req_bus.poll_tx_time  <= x.t1;
            req_bus.poll_rx_time  <= x.t2;
            req_bus.resp_tx_time  <= x.t3;
            req_bus.resp_rx_time  <= x.t4;
            req_bus.final_tx_time <= x.t5;
            req_bus.final_rx_time <= x.t6;
         end
         req_bus.valid <= drive;
      end
   end

   // receiver: random idling, one long hold-off so the pipeline backs up
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (!stall_done && words_sent >= 700) begin
         stall_done <= 1'b1;
         stall_left <= 150;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= (words_sent >= 300 && words_sent < 500) ||
                          $urandom_range(99) >= 23;
      end
   end

   always @(posedge clock) begin
      range_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_ranges.size() == 0) begin
            report("result words pending", 0, 1);
         end else begin
            want = expected_ranges.pop_front();
            if (rsp_bus.distance_cm !== want.dist_cm)
               report("distance_cm", rsp_bus.distance_cm, want.dist_cm);
            if (rsp_bus.valid_res !== want.ok) report("valid_res", rsp_bus.valid_res, want.ok);
            if (rsp_bus.saturated !== want.sat) report("saturated", rsp_bus.saturated, want.sat);
         end
      end
   end

   initial begin
      exchange_type x;
      stamp_type    top;
      top = '1;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.poll_tx_time = '0;
      req_bus.poll_rx_time = '0;
      req_bus.resp_tx_time = '0;
      req_bus.resp_rx_time = '0;
      req_bus.final_tx_time = '0;
      req_bus.final_rx_time = '0;
      rsp_bus.ready = 1'b0;

      // directed: zero intervals, all ones, wraps, invalid, saturation
      pending_words.push_back('0);
      pending_words.push_back('1);
      pending_words.push_back(make_exchange(top - 5, top - 3, 100, 4000, 3000));
      pending_words.push_back(make_exchange(top - 5000, 0, 200, 300, 50));
      pending_words.push_back(make_exchange(0, top - 10, 7, 20, 30));
      pending_words.push_back(make_exchange(123, 456, 0, 1000, 1000));
      pending_words.push_back(make_exchange(top - 2000, top - 2000, 70, 1500, 100));
      x = '0;
      x.t4 = stamp_type'(10);
      x.t5 = 40'hFF_0000_0000;
      x.t3 = 40'h80_0000_0000;
      x.t6 = x.t3 + stamp_type'(12);
      pending_words.push_back(x);
      x = '0;
      x.t4 = 40'h80_0000_0000;
      x.t5 = x.t4;
      x.t6 = 40'h80_0000_0000;
      pending_words.push_back(x);
      pending_words.push_back(make_exchange(1, 2, 140000, 1000, 1000));
      pending_words.push_back(make_exchange(1, 2, 139700, 1000, 1000));
      pending_words.push_back(make_exchange(40'h55_5555_5555, 40'hAA_AAAA_AAAA, 300, 70000,
                                            90000));
      pending_words.push_back('{top, '0, top, '0, top, '0});
      pending_words.push_back('{'0, top, '0, top, '0, top});

      for (int i = 0; i < 1100; i++) begin
         if ($urandom_range(9) < 2) begin
            x = {rand_stamp(), rand_stamp(), rand_stamp(), rand_stamp(), rand_stamp(),
                 rand_stamp()};
         end else begin
            x = make_exchange(rand_stamp(), rand_stamp(),
                              ($urandom_range(9) == 0) ? $urandom_range(300000) :
                                                         $urandom_range(2000),
                              $urandom_range(1 << 30), $urandom_range(1 << 30));
            // jitter on the final stamps, sometimes pushing the reply product above
            if ($urandom_range(3) == 0) begin
               x.t5 = x.t5 + stamp_type'($urandom_range(64));
               x.t6 = x.t6 - stamp_type'($urandom_range(64));
            end
         end
         pending_words.push_back(x);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      wait (pending_words.size() == 0 && expected_ranges.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_ranges.size() != 0) error_count++;
      if (error_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> sim.f
hdl/dstwr_pkg.sv
hdl/ds_twr_if.sv
hdl/ds_twr_distance_top.sv
sim/testbench.sv
